// ===== src/lspm_pkg.sv =====
// Shared types and constants for the load-shedding power manager.
package lspm_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int DEF_LOAD_SLOTS = 8;

    localparam logic [1:0] OP_VOLTAGE = 2'd0;
    localparam logic [1:0] OP_SOLAR   = 2'd1;
    localparam logic [1:0] OP_VELOCITY = 2'd2;
    localparam logic [1:0] OP_TICK    = 2'd3;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_LOW    = 2'd1;
    localparam logic [1:0] MODE_HIB    = 2'd2;
    localparam logic [1:0] MODE_EMERG  = 2'd3;

    localparam logic [2:0] REG_THRESH   = 3'd0;
    localparam logic [2:0] REG_HIB_SOL  = 3'd1;
    localparam logic [2:0] REG_LOW_BAL  = 3'd2;
    localparam logic [2:0] REG_NOMINAL  = 3'd3;
    localparam logic [2:0] REG_PRIO     = 3'd4;
    localparam logic [2:0] REG_ESSENT   = 3'd5;
    localparam logic [2:0] REG_SHED     = 3'd6;
    localparam logic [2:0] REG_MOTOR    = 3'd7;

    localparam logic [39:0] THRESH_RST  = 40'd429811814550;
    localparam logic [63:0] NOMINAL_RST = 64'd2890764590232700175;

    // controller to datapath commands
    typedef struct packed {
        logic       load;     // latch input item
        logic       sum_clr;  // clear accumulator, do non-tick op, start scan
        logic       sum_step; // add slot at scan index
        logic       sum_all;  // add every enabled slot, not only critical ones
        logic       decide;   // pick mode, apply rules
        logic       alloc_step;
        logic       alloc_init;
        logic       report;   // register result
        logic [2:0] slot;
        logic [1:0] prio;
    } lspm_cmd_t;

    typedef struct packed {
        logic is_tick;
    } lspm_stat_t;

endpackage

// ===== src/lspm_ctrl.sv =====
// Sequencer that walks the slots for sums and allocation.
module lspm_ctrl
    import lspm_pkg::*;
#(
    parameter int LOAD_SLOTS = DEF_LOAD_SLOTS
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic       out_busy,
    input  lspm_stat_t stat,
    output logic       idle,
    output lspm_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_DEC   = 3'd3;
    localparam logic [2:0] S_ALLOC = 3'd4;
    localparam logic [2:0] S_CRIT  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;
    localparam logic [2:0] LAST = 3'(LOAD_SLOTS - 1);

    logic [2:0] state_reg, state_next;
    logic [2:0] slot_reg, slot_next;
    logic [1:0] prio_reg, prio_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            slot_reg  <= '0;
            prio_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            prio_reg  <= prio_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        prio_next  = prio_reg;
        cmd = '0;
        cmd.slot = slot_reg;
        cmd.prio = prio_reg;
        idle = (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.sum_clr = 1'b1;
                slot_next = '0;
                prio_next = '0;
                state_next = stat.is_tick ? S_SUM : S_CRIT;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                cmd.sum_all = 1'b1;
                slot_next = slot_reg + 3'd1;
                if (slot_reg == LAST)
                begin
                    slot_next = '0;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.decide = 1'b1;
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                cmd.alloc_step = 1'b1;
                cmd.alloc_init = (slot_reg == '0) && (prio_reg == '0);
                slot_next = slot_reg + 3'd1;
                if (slot_reg == LAST)
                begin
                    slot_next = '0;
                    prio_next = prio_reg + 2'd1;
                    if (prio_reg == 2'd3)
                    begin
                        state_next = S_CRIT;
                        cmd.sum_clr = 1'b1;
                    end
                end
            end
            S_CRIT:
            begin
                cmd.sum_step = 1'b1;
                slot_next = slot_reg + 3'd1;
                if (slot_reg == LAST)
                begin
                    slot_next = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_busy)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule

// ===== src/lspm_dp.sv =====
// Datapath: state registers, per-slot arithmetic and result register.
module lspm_dp
    import lspm_pkg::*;
#(
    parameter int LOAD_SLOTS = DEF_LOAD_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  lspm_cmd_t   cmd,
    input  logic [1:0]  opcode,
    input  logic [15:0] voltage_mv,
    input  logic [15:0] pv_power,
    input  logic signed [15:0] linear_speed,
    input  logic signed [15:0] angular_rate,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        out_ready,
    output lspm_stat_t  stat,
    output logic        out_valid,
    output logic [55:0] out_data
);
    logic [39:0] thr_reg;
    logic [15:0] hib_reg;
    logic signed [15:0] lowbal_reg;
    logic [63:0] nom_reg;
    logic [15:0] prio_reg;
    logic [7:0]  ess_reg, shed_reg;
    logic [2:0]  motor_reg;

    logic [1:0]  op_reg;
    logic [15:0] vin_reg, sin_reg, lin_reg, ang_reg;
    logic [1:0]  mode_reg;
    logic        chg_reg;
    logic [9:0]  charge_reg;
    logic [15:0] solar_reg;
    logic [18:0] total_reg, acc_reg;
    logic [15:0] avail_reg;
    logic [MAX_SLOTS-1:0] en_reg;
    logic [15:0] draw_reg [MAX_SLOTS];
    logic        ov_reg;
    logic [55:0] od_reg;

    localparam logic [15:0] DRAW_RST [MAX_SLOTS] =
        '{16'd150, 16'd50, 16'd250, 16'd0, 16'd200, 16'd150, 16'd0, 16'd0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESH_RST;
            hib_reg <= 16'd50;
            lowbal_reg <= -16'sd100;
            nom_reg <= NOMINAL_RST;
            prio_reg <= 16'd47696;
            ess_reg <= 8'd15;
            shed_reg <= 8'd32;
            motor_reg <= 3'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_THRESH:  thr_reg <= cfg_data[39:0];
                REG_HIB_SOL: hib_reg <= cfg_data[15:0];
                REG_LOW_BAL: lowbal_reg <= cfg_data[15:0];
                REG_NOMINAL: nom_reg <= cfg_data;
                REG_PRIO:    prio_reg <= cfg_data[15:0];
                REG_ESSENT:  ess_reg <= cfg_data[7:0];
                REG_SHED:    shed_reg <= cfg_data[7:0];
                REG_MOTOR:   motor_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= opcode;
            vin_reg <= voltage_mv;
            sin_reg <= pv_power;
            lin_reg <= linear_speed;
            ang_reg <= angular_rate;
        end
    end
    assign stat.is_tick = (op_reg == OP_TICK);

    // non-tick arithmetic, done in the cycle after load
    logic [15:0] vd;
    logic [18:0] v5;
    logic [31:0] vq;
    logic [15:0] la, aa;
    logic [25:0] vsum;
    logic [17:0] dnew;
    logic [15:0] dsat;
    always_comb
    begin
        vd = (vin_reg > 16'd24000) ? vin_reg - 16'd24000 : 16'd0;
        v5 = {3'd0, vd} * 19'd5;
        // divide by 27 via reciprocal; correct once
        vq = 32'((64'(v5) * 64'd19884108) >> 29);
        if (v5 - 19'(vq * 32'd27) >= 19'd27)
            vq = vq + 32'd1;
        la = lin_reg[15] ? 16'(-lin_reg) : lin_reg;
        aa = ang_reg[15] ? 16'(-ang_reg) : ang_reg;
        if (lin_reg == 16'h8000) la = 16'h8000;
        if (ang_reg == 16'h8000) aa = 16'h8000;
        vsum = 26'(la) * 26'd400 + 26'(aa) * 26'd200;
        dnew = 18'd100 + 18'(vsum >> 8);
        dsat = (dnew > 18'd65535) ? 16'hFFFF : dnew[15:0];
    end

    // slot under scan
    logic [1:0]  sp;
    logic [15:0] snom, sdraw;
    logic        sen;
    always_comb
    begin
        sp = prio_reg[2*cmd.slot +: 2];
        snom = 16'(nom_reg[8*cmd.slot +: 8]) * 16'd10;
        sdraw = draw_reg[cmd.slot];
        sen = en_reg[cmd.slot];
    end

    // mode decision, on the sum just found
    logic signed [19:0] bal;
    logic [1:0] tgt;
    logic [MAX_SLOTS-1:0] en_new;
    always_comb
    begin
        bal = $signed({4'd0, solar_reg}) - $signed({1'b0, acc_reg});
        if (charge_reg < thr_reg[9:0])
            tgt = MODE_EMERG;
        else if (solar_reg < hib_reg && charge_reg < thr_reg[19:10])
            tgt = MODE_HIB;
        else if (charge_reg < thr_reg[29:20] || bal < 20'(lowbal_reg))
            tgt = MODE_LOW;
        else if (charge_reg > thr_reg[39:30] && bal > 20'sd0)
            tgt = MODE_NORMAL;
        else
            tgt = mode_reg;
        for (int s = 0; s < MAX_SLOTS; s++)
        begin
            en_new[s] = en_reg[s];
            unique case (tgt)
                MODE_NORMAL: en_new[s] = 1'b1;
                MODE_LOW:
                    if (prio_reg[2*s +: 2] == 2'd3 || shed_reg[s]) en_new[s] = 1'b0;
                MODE_HIB:
                    if (prio_reg[2*s +: 2] != 2'd0 && !ess_reg[s]) en_new[s] = 1'b0;
                default: en_new[s] = (prio_reg[2*s +: 2] == 2'd0);
            endcase
            if (s >= LOAD_SLOTS) en_new[s] = 1'b0;
        end
    end

    logic [15:0] av;
    logic [18:0] crit_sp;
    always_comb
    begin
        av = cmd.alloc_init ? solar_reg : avail_reg;
        crit_sp = (19'(solar_reg) > acc_reg) ? 19'(solar_reg) - acc_reg : 19'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            chg_reg <= 1'b0;
            charge_reg <= 10'd1000;
            solar_reg <= '0;
            total_reg <= '0;
            for (int s = 0; s < MAX_SLOTS; s++)
            begin
                en_reg[s] <= (s < LOAD_SLOTS);
                draw_reg[s] <= DRAW_RST[s];
            end
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load) chg_reg <= 1'b0;
            if (cmd.sum_clr && !cmd.alloc_step)
            begin
                unique case (op_reg)
                    OP_VOLTAGE: charge_reg <= (vq > 32'd1000) ? 10'd1000 : vq[9:0];
                    OP_SOLAR:   solar_reg <= sin_reg;
                    OP_VELOCITY:
                        if (32'(motor_reg) < LOAD_SLOTS) draw_reg[motor_reg] <= dsat;
                    default: ;
                endcase
            end
            if (cmd.decide)
            begin
                total_reg <= acc_reg;
                if (tgt != mode_reg)
                begin
                    mode_reg <= tgt;
                    chg_reg <= 1'b1;
                    en_reg <= en_new;
                end
            end
            if (cmd.alloc_step && sen && sp == cmd.prio && 32'(cmd.slot) < LOAD_SLOTS)
                draw_reg[cmd.slot] <= (av >= snom) ? snom : av;
            if (cmd.report)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_clr)
            acc_reg <= '0;
        else if (cmd.sum_step && sen && 32'(cmd.slot) < LOAD_SLOTS
                 && (cmd.sum_all || sp == 2'd0) && !cmd.decide)
            acc_reg <= acc_reg + 19'(sdraw);
        if (cmd.alloc_step)
        begin
            if (sen && sp == cmd.prio && 32'(cmd.slot) < LOAD_SLOTS)
                avail_reg <= (av >= snom) ? av - snom : 16'd0;
            else
                avail_reg <= av;
        end
        if (cmd.report)
            od_reg <= {en_reg, total_reg, crit_sp[15:0], charge_reg, chg_reg, mode_reg};
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;
endmodule

// ===== src/load_shedding_power_manager.sv =====
// Top level of the load-shedding power manager.
// Samples and commands pass through load, one crit pass over the slots and report;
// a tick passes through load, the draw sum (one slot per cycle), decide, four
// priority passes and one crit pass, then report.
// One item at a time: a new item is accepted only once the last one is reported;
// a waiting result holds the next report. Reset restores configuration, mode, charge, solar, draws and enables.
module load_shedding_power_manager
    import lspm_pkg::*;
#(
    parameter int LOAD_SLOTS = DEF_LOAD_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: voltage_mv, pv_power, linear_speed, angular_rate
    input  logic [63:0] s_axis_tdata,
    // tuser: opcode
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: power_mode, mode_changed, charge_permille, spare_power,
    // total_draw, enable_bits
    output logic [55:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);
    lspm_cmd_t  cmd;
    lspm_stat_t stat;
    logic idle;

    assign s_axis_tready = idle;

    lspm_ctrl #(.LOAD_SLOTS(LOAD_SLOTS)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_fire(s_axis_tvalid && s_axis_tready),
        .out_busy(m_axis_tvalid && !m_axis_tready),
        .stat(stat), .idle(idle), .cmd(cmd)
    );

    lspm_dp #(.LOAD_SLOTS(LOAD_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .opcode(s_axis_tuser),
        .voltage_mv(s_axis_tdata[15:0]),
        .pv_power(s_axis_tdata[31:16]),
        .linear_speed(s_axis_tdata[47:32]),
        .angular_rate(s_axis_tdata[63:48]),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_ready(m_axis_tready), .stat(stat),
        .out_valid(m_axis_tvalid), .out_data(m_axis_tdata)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.decide && cmd.alloc_step)) else $error("decide overlaps alloc");
    a_acc_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.report |=> m_axis_tvalid) else $error("result lost");
    a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
        !idle |-> !s_axis_tready) else $error("accept while busy");
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the load-shedding power manager: table-driven directed items, then random ones.
module tb;
    import lspm_pkg::*;

    typedef struct packed {
        logic [15:0] angular_rate;
        logic [15:0] linear_speed;
        logic [15:0] pv_power;
        logic [15:0] voltage_mv;
    } cmd_data_t;

    typedef struct packed {
        logic [7:0]  enable_bits;
        logic [18:0] total_draw;
        logic [15:0] spare_power;
        logic [9:0]  charge_permille;
        logic        mode_changed;
        logic [1:0]  power_mode;
    } status_t;

    typedef struct {
        logic [1:0] op;
        cmd_data_t  data;
        logic       has_known;
        status_t    known;
    } stim_row_t;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [55:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    // predictor state
    logic [39:0] thresh_cfg;
    logic [15:0] hib_solar_cfg;
    logic signed [15:0] low_bal_cfg;
    logic [63:0] nominal_cfg;
    logic [15:0] prio_cfg;
    logic [7:0]  essential_cfg;
    logic [7:0]  shed_cfg;
    logic [2:0]  motor_cfg;
    logic [1:0]  mode_q;
    logic [9:0]  charge_q;
    logic [15:0] solar_q;
    logic [18:0] total_q;
    logic [7:0]  enable_q;
    logic [15:0] draw_q [8];

    status_t     status_queue[$];
    logic        known_queue[$];
    status_t     known_vals[$];
    int          mismatches;
    int          idle_cycles;
    bit          timed_out;
    bit          hold_sink;
    int          sink_hold_cycles;
    stim_row_t   directed[$];

    dut_wrap_unused_guard u_unused();

    load_shedding_power_manager i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [1:0] prio_of(input int s);
        return prio_cfg[2*s +: 2];
    endfunction

    task automatic predictor_reset();
        thresh_cfg = THRESH_RST;
        hib_solar_cfg = 16'd50;
        low_bal_cfg = -16'sd100;
        nominal_cfg = NOMINAL_RST;
        prio_cfg = 16'd47696;
        essential_cfg = 8'd15;
        shed_cfg = 8'd32;
        motor_cfg = 3'd3;
        mode_q = MODE_NORMAL;
        charge_q = 10'd1000;
        solar_q = '0;
        total_q = '0;
        enable_q = 8'hFF;
        draw_q = '{16'd150, 16'd50, 16'd250, 16'd0, 16'd200, 16'd150, 16'd0, 16'd0};
    endtask

    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? 16'(17'h10000 - {1'b0, v}) : v;
    endfunction

    function automatic status_t manager_step(input logic [1:0] op, input cmd_data_t d);
        status_t r;
        logic [1:0] tgt;
        int unsigned total, crit, avail, nom, draw;
        int balance;
        logic [9:0] lim [4];
        for (int k = 0; k < 4; k++)
            lim[k] = thresh_cfg[10*k +: 10];
        r = '0;
        case (op)
            OP_VOLTAGE:
            begin
                draw = (d.voltage_mv > 24000) ? (d.voltage_mv - 24000) * 5 / 27 : 0;
                charge_q = (draw > 1000) ? 10'd1000 : 10'(draw);
            end
            OP_SOLAR:
                solar_q = d.pv_power;
            OP_VELOCITY:
            begin
                draw = 100 + ((400 * mag16(d.linear_speed) + 200 * mag16(d.angular_rate)) >> 8);
                draw_q[motor_cfg] = (draw > 65535) ? 16'hFFFF : 16'(draw);
            end
            default:
            begin
                total = 0;
                for (int s = 0; s < 8; s++)
                    if (enable_q[s])
                        total += draw_q[s];
                total_q = 19'(total);
                balance = int'(solar_q) - int'(total_q);
                if (charge_q < lim[0])
                    tgt = MODE_EMERG;
                else if (solar_q < hib_solar_cfg && charge_q < lim[1])
                    tgt = MODE_HIB;
                else if (charge_q < lim[2] || balance < int'(low_bal_cfg))
                    tgt = MODE_LOW;
                else if (charge_q > lim[3] && balance > 0)
                    tgt = MODE_NORMAL;
                else
                    tgt = mode_q;
                if (tgt != mode_q)
                begin
                    mode_q = tgt;
                    r.mode_changed = 1'b1;
                    for (int s = 0; s < 8; s++)
                        case (tgt)
                            MODE_NORMAL: enable_q[s] = 1'b1;
                            MODE_LOW:
                                if (prio_of(s) == 2'd3 || shed_cfg[s])
                                    enable_q[s] = 1'b0;
                            MODE_HIB:
                                if (prio_of(s) != 2'd0 && !essential_cfg[s])
                                    enable_q[s] = 1'b0;
                            default: enable_q[s] = (prio_of(s) == 2'd0);
                        endcase
                end
                avail = solar_q;
                for (int p = 0; p < 4; p++)
                    for (int s = 0; s < 8; s++)
                        if (enable_q[s] && prio_of(s) == p)
                        begin
                            nom = nominal_cfg[8*s +: 8] * 10;
                            if (avail >= nom)
                            begin
                                draw_q[s] = 16'(nom);
                                avail -= nom;
                            end
                            else
                            begin
                                draw_q[s] = 16'(avail);
                                avail = 0;
                            end
                        end
            end
        endcase
        crit = 0;
        for (int s = 0; s < 8; s++)
            if (enable_q[s] && prio_of(s) == 2'd0)
                crit += draw_q[s];
        r.power_mode = mode_q;
        r.charge_permille = charge_q;
        r.spare_power = (solar_q > crit) ? 16'(solar_q - crit) : 16'd0;
        r.total_draw = total_q;
        r.enable_bits = enable_q;
        return r;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_THRESH:  thresh_cfg = val[39:0];
            REG_HIB_SOL: hib_solar_cfg = val[15:0];
            REG_LOW_BAL: low_bal_cfg = val[15:0];
            REG_NOMINAL: nominal_cfg = val;
            REG_PRIO:    prio_cfg = val[15:0];
            REG_ESSENT:  essential_cfg = val[7:0];
            REG_SHED:    shed_cfg = val[7:0];
            default:     motor_cfg = val[2:0];
        endcase
    endtask

    task automatic send_item(input logic [1:0] op, input cmd_data_t d,
                             input logic has_known, input status_t known);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        // the previous item's transfer has already ended; wait out the drawn gap
        repeat (gap + 1) @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= d;
        status_queue.insert(status_queue.size(), manager_step(op, d));
        known_queue.insert(known_queue.size(), has_known);
        known_vals.insert(known_vals.size(), known);
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (status_queue.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic cmd_data_t rand_data();
        cmd_data_t d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: d.voltage_mv = 16'($urandom_range(23000, 30000));
            1: d.pv_power = 16'($urandom_range(0, 3000));
            default: ;
        endcase
        if ($urandom_range(0, 2) != 0)
        begin
            d.linear_speed = 16'($urandom_range(0, 1024) - 512);
            d.angular_rate = 16'($urandom_range(0, 1024) - 512);
        end
        return d;
    endfunction

    task automatic random_items(input int n);
        cmd_data_t d;
        logic [1:0] op;
        for (int i = 0; i < n; i++)
        begin
            d = rand_data();
            op = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 2) == 0)
                op = OP_TICK;
            send_item(op, d, 1'b0, '0);
        end
    endtask

    function automatic stim_row_t row(input logic [1:0] op, input logic [15:0] a,
                                      input logic [15:0] b, input logic [15:0] c,
                                      input logic [15:0] e);
        stim_row_t r;
        r.op = op;
        r.data = {e, c, b, a};
        r.has_known = 1'b0;
        r.known = '0;
        return r;
    endfunction

    // sink: a drawn wait before each transfer, and a long hold when asked
    initial
    begin
        int sink_wait;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_hold_cycles) @(negedge clk);
                hold_sink = 1'b0;
            end
            sink_wait = $urandom_range(0, 9);
            if (sink_wait != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (sink_wait) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            @(negedge clk);
        end
    end

    // checker
    always @(posedge clk)
    begin
        status_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (status_queue.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transfer %h", got);
            end
            else
            begin
                want = known_queue[0] ? known_vals[0] : status_queue[0];
                if (known_queue[0] && known_vals[0] != status_queue[0])
                    want = known_vals[0];
                void'(status_queue.pop_front());
                void'(known_queue.pop_front());
                void'(known_vals.pop_front());
                if (got.power_mode !== want.power_mode
                    || got.mode_changed !== want.mode_changed
                    || got.charge_permille !== want.charge_permille
                    || got.spare_power !== want.spare_power
                    || got.total_draw !== want.total_draw
                    || got.enable_bits !== want.enable_bits)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        status_t k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_VOLTAGE;
        cfg_we = 1'b0;
        cfg_index = REG_THRESH;
        cfg_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        hold_sink = 1'b0;
        sink_hold_cycles = 0;
        predictor_reset();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // state straight after reset, via a solar sample of zero
        directed.insert(directed.size(), row(OP_SOLAR, 16'd0, 16'd0, 16'd0, 16'd0));
        k = '0;
        k.power_mode = MODE_NORMAL;
        k.charge_permille = 10'd1000;
        k.enable_bits = 8'hFF;
        directed[0].has_known = 1'b1;
        directed[0].known = k;
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'hFFFF, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd24000, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd24001, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd26000, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_SOLAR, 16'd0, 16'hFFFF, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VELOCITY, 16'd0, 16'd0, 16'h8000, 16'h8000));
        directed.insert(directed.size(), row(OP_VELOCITY, 16'd0, 16'd0, 16'h7FFF, 16'hFFFF));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd28000, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_SOLAR, 16'd0, 16'd10, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd25000, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd24500, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_SOLAR, 16'd0, 16'd400, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_VOLTAGE, 16'd30000, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        directed.insert(directed.size(), row(OP_TICK, 16'd0, 16'd0, 16'd0, 16'd0));
        foreach (directed[i])
            send_item(directed[i].op, directed[i].data, directed[i].has_known,
                      directed[i].known);
        random_items(300);

        // fill up while the sink holds off
        sink_hold_cycles = 300;
        hold_sink = 1'b1;
        random_items(20);
        drain();

        // extremes of every register
        write_reg(REG_THRESH, 64'hFF_FFFF_FFFF);
        write_reg(REG_HIB_SOL, 64'hFFFF);
        write_reg(REG_LOW_BAL, 64'h8000);
        write_reg(REG_NOMINAL, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_PRIO, 64'h0);
        write_reg(REG_ESSENT, 64'h0);
        write_reg(REG_SHED, 64'hFF);
        write_reg(REG_MOTOR, 64'h7);
        random_items(300);
        drain();

        write_reg(REG_THRESH, 64'h0);
        write_reg(REG_HIB_SOL, 64'h0);
        write_reg(REG_LOW_BAL, 64'h7FFF);
        write_reg(REG_NOMINAL, 64'h0);
        write_reg(REG_PRIO, 64'hFFFF);
        write_reg(REG_ESSENT, 64'hFF);
        write_reg(REG_SHED, 64'h0);
        write_reg(REG_MOTOR, 64'h0);
        random_items(300);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            write_reg(REG_THRESH, {$urandom_range(0, 255), $urandom});
            write_reg(REG_THRESH, 64'({10'($urandom_range(700, 1000)),
                                       10'($urandom_range(400, 700)),
                                       10'($urandom_range(150, 400)),
                                       10'($urandom_range(0, 150))}));
            write_reg(REG_HIB_SOL, 64'($urandom_range(0, 65535)));
            write_reg(REG_LOW_BAL, 64'($urandom_range(0, 65535)));
            write_reg(REG_NOMINAL, {$urandom, $urandom});
            write_reg(REG_PRIO, 64'($urandom_range(0, 65535)));
            write_reg(REG_ESSENT, 64'($urandom_range(0, 255)));
            write_reg(REG_SHED, 64'($urandom_range(0, 255)));
            write_reg(REG_MOTOR, 64'($urandom_range(0, 7)));
            random_items(300);
            drain();
        end

        if (mismatches == 0 && status_queue.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

module dut_wrap_unused_guard;
endmodule
